// ----- design/timed_page_rotation_defines.svh -----
// Assertion macros shared by the timed page rotation RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef TIMED_PAGE_ROTATION_DEFINES_SVH
`define TIMED_PAGE_ROTATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tpr_pkg.sv -----
// Shared types and constants for the timed page rotation block.
// No dependencies; imported by tpr_ctrl, tpr_dpath and timed_page_rotation.
package tpr_pkg;

    // Default values of the top-level parameters.
    localparam int PAGE_COUNT_DEF       = 8;
    localparam int ORDER_SLOTS_DEF      = 8;
    localparam int DEFAULT_PERIOD_S_DEF = 5;

    // Fixed field widths.
    localparam int MAX_PAGES  = 8;
    localparam int PAGE_W     = 3;
    localparam int LEN_W      = 4;
    localparam int TIME_W     = 32;
    localparam int SECS_W     = 16;
    localparam int MS_W       = 10;
    localparam int PERIOD_W   = 26;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    localparam logic [MS_W-1:0]  MS_PER_S  = 10'd1000;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;

    // Opcode carried in the input tuser.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_APPLY  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ORDER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ROTATE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PINNED_PAGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SECONDS = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic build_clr;
        logic slot_step;
        logic fill_step;
        logic cnt_clr;
        logic apply_latch;
        logic pin_eval;
        logic search_step;
        logic div_init;
        logic div_step;
        logic advance;
        logic out_load;
    } tpr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_apply;
        logic configured;
        logic auto_mode;
        logic short_list;
        logic slot_last;
        logic fill_last;
        logic search_end;
        logic div_last;
        logic out_free;
    } tpr_stat_t;

endpackage

// ----- design/tpr_ctrl.sv -----
// Sequencing state machine of the timed page rotation block.
// Depends on tpr_pkg for the command and status structs.
module tpr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tpr_pkg::tpr_stat_t stat,
    output tpr_pkg::tpr_cmd_t  cmd
);
    import tpr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SLOTS,
        ST_FILL,
        ST_APPLY,
        ST_PIN,
        ST_SEARCH,
        ST_DIVIDE,
        ST_ADVANCE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (stat.op_apply) begin
                    cmd.build_clr = 1'b1;
                    state_next    = ST_SLOTS;
                end else if (!stat.configured) begin
                    state_next = ST_FINISH;
                end else if (!stat.auto_mode) begin
                    state_next = ST_PIN;
                end else if (stat.short_list) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SLOTS: begin
                cmd.slot_step = 1'b1;
                if (stat.slot_last) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply_latch = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_PIN: begin
                cmd.pin_eval = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (stat.search_end) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/tpr_dpath.sv -----
// Datapath of the timed page rotation block: configuration registers, page list,
// bit-serial divider with running modulo, and the output register. Uses tpr_pkg.
`include "timed_page_rotation_defines.svh"

module tpr_dpath #(
    parameter int PAGE_COUNT       = tpr_pkg::PAGE_COUNT_DEF,
    parameter int ORDER_SLOTS      = tpr_pkg::ORDER_SLOTS_DEF,
    parameter int DEFAULT_PERIOD_S = tpr_pkg::DEFAULT_PERIOD_S_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tpr_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tpr_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [tpr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  tpr_pkg::tpr_cmd_t                   cmd,
    output tpr_pkg::tpr_stat_t                  stat
);
    import tpr_pkg::*;

    // Order slots beyond the eighth never hold a page.
    localparam int NSLOT = (ORDER_SLOTS < MAX_PAGES) ? ORDER_SLOTS : MAX_PAGES;
    localparam logic [MAX_PAGES-1:0] PAGE_MASK =
        (PAGE_COUNT >= MAX_PAGES) ? {MAX_PAGES{1'b1}} : MAX_PAGES'((1 << PAGE_COUNT) - 1);
    localparam logic [SECS_W-1:0]   DEF_SECS   = SECS_W'(DEFAULT_PERIOD_S);
    localparam logic [CNT_W-1:0]    SLOT_LAST  = CNT_W'(NSLOT - 1);
    localparam logic [CNT_W-1:0]    FILL_LAST  = CNT_W'(MAX_PAGES - 1);

    // Configuration registers.
    logic [MAX_PAGES-1:0]  enabled_mask_reg;
    logic [CFG_DATA_W-1:0] page_order_reg;
    logic                  auto_rotate_reg;
    logic [7:0]            pinned_page_reg;
    logic [SECS_W-1:0]     period_seconds_reg;

    // Control state.
    logic                  configured_reg;
    logic                  active_auto_reg;
    logic [7:0]            active_pinned_reg;
    logic [PERIOD_W-1:0]   active_period_reg;
    logic [MAX_PAGES-1:0]  active_enabled_reg;
    logic [PAGE_W-1:0]     current_page_reg;
    logic [TIME_W-1:0]     last_switch_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [MAX_PAGES-1:0]  added_reg;
    logic                  out_valid_reg;

    // Payload registers.
    logic [PAGE_W-1:0]     list_mem [MAX_PAGES];
    logic                  op_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     dividend_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PAGE_W-1:0]     mod_reg;
    logic [PAGE_W-1:0]     idx_reg;
    logic                  q_any_reg;
    logic                  changed_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Combinational terms.
    logic [MAX_PAGES-1:0]  enabled_eff;
    logic [7:0]            slot_byte;
    logic                  slot_ok;
    logic [PAGE_W-1:0]     fill_page;
    logic                  fill_ok;
    logic                  build_wr;
    logic [PAGE_W-1:0]     build_page;
    logic [SECS_W-1:0]     secs_eff;
    logic [PERIOD_W-1:0]   period_next;
    logic [PAGE_W-1:0]     rd_addr;
    logic [PAGE_W-1:0]     rd_page;
    logic                  search_hit;
    logic [PERIOD_W:0]     rem_shift;
    logic                  q_bit;
    logic [PERIOD_W-1:0]   rem_next;
    logic [LEN_W-1:0]      mod_shift;
    logic [PAGE_W-1:0]     mod_next;
    logic [LEN_W-1:0]      pos_sum;
    logic [LEN_W-1:0]      pos_wrap;
    logic [PAGE_W-1:0]     apply_page;
    logic [PAGE_W-1:0]     pin_page;

    // Pinned choice: the pinned page if it is a valid listed page, else the first entry.
    function automatic logic [PAGE_W-1:0] pin_choice(
        input logic [7:0]           pinned,
        input logic [MAX_PAGES-1:0] enabled,
        input logic [PAGE_W-1:0]    first_page
    );
        logic ok;
        ok = (pinned[7:PAGE_W] == '0) && enabled[pinned[PAGE_W-1:0]];
        return ok ? pinned[PAGE_W-1:0] : first_page;
    endfunction

    // Enabled set for the list build; an empty set falls back to page 0.
    always_comb begin
        enabled_eff = enabled_mask_reg & PAGE_MASK;
        if (enabled_eff == '0) begin
            enabled_eff = MAX_PAGES'(1);
        end
    end

    // List build candidates: order slots first, then the remaining pages ascending.
    assign slot_byte  = page_order_reg[8*cnt_reg[PAGE_W-1:0] +: 8];
    assign slot_ok    = (slot_byte[7:PAGE_W] == '0) && enabled_eff[slot_byte[PAGE_W-1:0]]
                        && !added_reg[slot_byte[PAGE_W-1:0]];
    assign fill_page  = cnt_reg[PAGE_W-1:0];
    assign fill_ok    = enabled_eff[fill_page] && !added_reg[fill_page];
    assign build_wr   = (cmd.slot_step && slot_ok) || (cmd.fill_step && fill_ok);
    assign build_page = cmd.slot_step ? slot_byte[PAGE_W-1:0] : fill_page;

    // Period in milliseconds.
    assign secs_eff    = (period_seconds_reg == '0) ? DEF_SECS : period_seconds_reg;
    assign period_next = PERIOD_W'(secs_eff * MS_PER_S);

    // One restoring divide step; the quotient bit also feeds a running modulo by the length.
    assign rem_shift = {rem_reg, dividend_reg[TIME_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, active_period_reg});
    assign rem_next  = q_bit ? PERIOD_W'(rem_shift - {1'b0, active_period_reg})
                             : rem_shift[PERIOD_W-1:0];
    assign mod_shift = {mod_reg, q_bit};
    assign mod_next  = (mod_shift >= len_reg) ? PAGE_W'(mod_shift - len_reg)
                                              : mod_shift[PAGE_W-1:0];

    // New list position after advancing.
    assign pos_sum  = LEN_W'(idx_reg) + LEN_W'(mod_reg);
    assign pos_wrap = (pos_sum >= len_reg) ? (pos_sum - len_reg) : pos_sum;

    // Single list read port.
    always_comb begin
        priority if (cmd.search_step) begin
            rd_addr = cnt_reg[PAGE_W-1:0];
        end else if (cmd.advance) begin
            rd_addr = pos_wrap[PAGE_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end
    assign rd_page    = list_mem[rd_addr];
    assign search_hit = (rd_page == current_page_reg);

    // Page chosen when a new configuration is applied.
    assign pin_page   = pin_choice(active_pinned_reg, active_enabled_reg, rd_page);
    always_comb begin
        if (auto_rotate_reg) begin
            apply_page = (configured_reg && enabled_eff[current_page_reg]) ?
                         current_page_reg : rd_page;
        end else begin
            apply_page = pin_choice(pinned_page_reg, enabled_eff, rd_page);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_mask_reg   <= MAX_PAGES'(1);
            page_order_reg     <= '0;
            auto_rotate_reg    <= 1'b0;
            pinned_page_reg    <= '0;
            period_seconds_reg <= '0;
            configured_reg     <= 1'b0;
            active_auto_reg    <= 1'b0;
            active_pinned_reg  <= '0;
            active_period_reg  <= '0;
            active_enabled_reg <= '0;
            current_page_reg   <= '0;
            last_switch_reg    <= '0;
            len_reg            <= '0;
            cnt_reg            <= '0;
            added_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            // Configuration writes; unknown indexes are dropped.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ENABLED_MASK:   enabled_mask_reg   <= cfg_wdata[MAX_PAGES-1:0];
                    CFG_PAGE_ORDER:     page_order_reg     <= cfg_wdata;
                    CFG_AUTO_ROTATE:    auto_rotate_reg    <= cfg_wdata[0];
                    CFG_PINNED_PAGE:    pinned_page_reg    <= cfg_wdata[7:0];
                    CFG_PERIOD_SECONDS: period_seconds_reg <= cfg_wdata[SECS_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Shared step counter.
            if (cmd.load_in || cmd.build_clr || cmd.cnt_clr || cmd.div_init) begin
                cnt_reg <= '0;
            end else if (cmd.slot_step || cmd.fill_step || cmd.search_step || cmd.div_step) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            // List length and membership during a build.
            if (cmd.build_clr) begin
                len_reg   <= '0;
                added_reg <= '0;
            end else if (build_wr) begin
                len_reg               <= len_reg + LEN_W'(1);
                added_reg[build_page] <= 1'b1;
            end

            // Latch the applied configuration.
            if (cmd.apply_latch) begin
                configured_reg     <= 1'b1;
                active_auto_reg    <= auto_rotate_reg;
                active_pinned_reg  <= pinned_page_reg;
                active_period_reg  <= period_next;
                active_enabled_reg <= enabled_eff;
                current_page_reg   <= apply_page;
                last_switch_reg    <= now_reg;
            end

            if (cmd.pin_eval) begin
                current_page_reg <= pin_page;
            end

            // A nonzero step count moves the page and the switch time.
            if (cmd.advance && q_any_reg) begin
                current_page_reg <= rd_page;
                last_switch_reg  <= now_reg - TIME_W'(rem_reg);
            end

            // Output valid: set on load, cleared when the transaction completes.
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg      <= s_tuser;
            now_reg     <= s_tdata;
            idx_reg     <= '0;
            changed_reg <= 1'b0;
        end

        if (build_wr) begin
            list_mem[len_reg[PAGE_W-1:0]] <= build_page;
        end

        if (cmd.search_step && search_hit) begin
            idx_reg <= cnt_reg[PAGE_W-1:0];
        end

        if (cmd.div_init) begin
            dividend_reg <= now_reg - last_switch_reg;
            rem_reg      <= '0;
            mod_reg      <= '0;
            q_any_reg    <= 1'b0;
        end else if (cmd.div_step) begin
            dividend_reg <= {dividend_reg[TIME_W-2:0], 1'b0};
            rem_reg      <= rem_next;
            mod_reg      <= mod_next;
            q_any_reg    <= q_any_reg | q_bit;
        end

        if (cmd.pin_eval) begin
            changed_reg <= (pin_page != current_page_reg);
        end
        if (cmd.advance) begin
            changed_reg <= q_any_reg;
        end

        if (cmd.out_load) begin
            out_data_reg <= {{(OUT_DATA_W - PAGE_W - 1){1'b0}}, current_page_reg, changed_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Status to the controller.
    always_comb begin
        stat            = '0;
        stat.op_apply   = (op_reg == OP_APPLY);
        stat.configured = configured_reg;
        stat.auto_mode  = active_auto_reg;
        stat.short_list = (len_reg <= LEN_W'(1));
        stat.slot_last  = (cnt_reg == SLOT_LAST);
        stat.fill_last  = (cnt_reg == FILL_LAST);
        stat.search_end = search_hit || (cnt_reg == (CNT_W'(len_reg) - CNT_W'(1)));
        stat.div_last   = (cnt_reg == DIV_LAST);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    // The shown page is always one of the listed pages once configured.
    `TPR_ASSERT_IMPL(a_current_listed, aclk, aresetn, configured_reg, active_enabled_reg[current_page_reg], "current page is not in the page list")
    // The divider remainder stays below the period throughout the division.
    `TPR_ASSERT_IMPL(a_rem_below_period, aclk, aresetn, cmd.div_step, rem_reg < active_period_reg, "divider remainder reached the period")
    // A finished build always holds at least one and at most all pages.
    `TPR_ASSERT_IMPL(a_list_length, aclk, aresetn, cmd.apply_latch, (len_reg != '0) && (len_reg <= LEN_W'(MAX_PAGES)), "page list length out of range")
    // Applying restarts the switch timer at the item's time stamp.
    `TPR_ASSERT_NEXT(a_apply_time, aclk, aresetn, cmd.apply_latch, configured_reg && (last_switch_reg == $past(now_reg)), "apply did not restart the timer")

endmodule

// ----- design/timed_page_rotation.sv -----
// Timed page rotation: one result transaction per input transaction. An apply item
// (tuser 1) builds the page list one order slot and then one page per cycle, over
// min(ORDER_SLOTS, 8) order slots and then all pages. An auto-mode update with two or
// more listed pages searches the list for the current page and then runs the bit-serial
// divider that works out the number of elapsed periods. A new item is taken while the
// previous result still waits in the output register. Configuration should be written
// through cfg_wr_en, cfg_index and cfg_wdata only while the block is idle; the block itself
// does not enforce this. The configuration is used by the next apply item.
// Depends on tpr_pkg, tpr_ctrl and tpr_dpath.
module timed_page_rotation #(
    parameter int PAGE_COUNT       = tpr_pkg::PAGE_COUNT_DEF,
    parameter int ORDER_SLOTS      = tpr_pkg::ORDER_SLOTS_DEF,
    parameter int DEFAULT_PERIOD_S = tpr_pkg::DEFAULT_PERIOD_S_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tpr_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] now_ms
    input  logic                           s_tuser,   // [0] opcode
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tpr_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] changed, [3:1] shown_page, [7:4] zero
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tpr_pkg::*;

    tpr_cmd_t  cmd;
    tpr_stat_t stat;

    // Sequencer.
    tpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Registers, list, divider and output stage.
    tpr_dpath #(
        .PAGE_COUNT       (PAGE_COUNT),
        .ORDER_SLOTS      (ORDER_SLOTS),
        .DEFAULT_PERIOD_S (DEFAULT_PERIOD_S)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
